// ===== rtl/core/dmgs_pkg.sv =====
package dmgs_pkg;

  // Default number of rows on the display.
  localparam int unsigned ROWS_DEFAULT = 7;

  // Field widths of the channels.
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned GLYPH_W     = 5;
  localparam int unsigned OUT_ROW_W   = 3;
  localparam int unsigned REFRESH_W   = 10;
  localparam int unsigned ANIMATE_W   = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // Output queue depth and its fill-count width.
  localparam int unsigned OUT_DEPTH   = 3;
  localparam int unsigned OUT_CNT_W   = 2;
  localparam int unsigned OUT_PTR_W   = 2;

  // Reset values of the period registers.
  localparam logic [REFRESH_W-1:0] REFRESH_RESET = 10'd10;
  localparam logic [ANIMATE_W-1:0] ANIMATE_RESET = 16'd300;

  // Special glyphs.
  localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 5'd11;
  localparam logic [GLYPH_W-1:0] GLYPH_UP    = 5'd13;
  localparam logic [GLYPH_W-1:0] GLYPH_DOWN  = 5'd14;
  localparam logic [GLYPH_W-1:0] GLYPH_AUTO  = 5'd15;
  localparam logic [GLYPH_W-1:0] GLYPH_SPORT = 5'd16;
  localparam logic [GLYPH_W-1:0] GLYPH_QUIT  = 5'd17;
  localparam logic [GLYPH_W-1:0] GLYPH_WAIT  = 5'd18;
  localparam logic [GLYPH_W-1:0] GLYPH_LOCK  = 5'd19;

  // Gear command bytes.
  localparam logic [CODE_W-1:0] CODE_DIGIT_LO = 8'h30;
  localparam logic [CODE_W-1:0] CODE_DIGIT_HI = 8'h3C;
  localparam logic [CODE_W-1:0] CODE_UP       = 8'h75;
  localparam logic [CODE_W-1:0] CODE_DOWN     = 8'h64;
  localparam logic [CODE_W-1:0] CODE_AUTO     = 8'h61;
  localparam logic [CODE_W-1:0] CODE_SPORT    = 8'h73;
  localparam logic [CODE_W-1:0] CODE_QUIT     = 8'h71;
  localparam logic [CODE_W-1:0] CODE_WAIT     = 8'h77;
  localparam logic [CODE_W-1:0] CODE_LOCK     = 8'h6C;

  typedef enum logic {
    FUNC_SET  = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REFRESH_PERIOD = 1'b0,
    REG_ANIMATE_PERIOD = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] scan_row;
    logic [GLYPH_W-1:0]   font_glyph;
    logic [OUT_ROW_W-1:0] font_row;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t item;
  } push_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 empty;
  } fifo_stat_t;

  // Maps a gear command byte to a font ROM glyph index.
  function automatic logic [GLYPH_W-1:0] map_code(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0]  diff;
    logic [GLYPH_W-1:0] glyph;
    diff = code - CODE_DIGIT_LO;
    if ((code >= CODE_DIGIT_LO) && (code <= CODE_DIGIT_HI)) begin
      glyph = diff[GLYPH_W-1:0];
    end else begin
      case (code)
        CODE_UP:    glyph = GLYPH_UP;
        CODE_DOWN:  glyph = GLYPH_DOWN;
        CODE_AUTO:  glyph = GLYPH_AUTO;
        CODE_SPORT: glyph = GLYPH_SPORT;
        CODE_QUIT:  glyph = GLYPH_QUIT;
        CODE_WAIT:  glyph = GLYPH_WAIT;
        CODE_LOCK:  glyph = GLYPH_LOCK;
        default:    glyph = GLYPH_BLANK;
      endcase
    end
    return glyph;
  endfunction

endpackage

// ===== rtl/core/dmgs_if.sv =====
interface dmgs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [dmgs_pkg::CODE_W-1:0] code;

  modport source (output valid, output func, output code, input ready);
  modport sink   (input valid, input func, input code, output ready);
endinterface

interface dmgs_out_if;
  logic                           valid;
  logic                           ready;
  logic [dmgs_pkg::OUT_ROW_W-1:0] scan_row;
  logic [dmgs_pkg::GLYPH_W-1:0]   font_glyph;
  logic [dmgs_pkg::OUT_ROW_W-1:0] font_row;

  modport source (output valid, output scan_row, output font_glyph, output font_row,
                  input ready);
  modport sink   (input valid, input scan_row, input font_glyph, input font_row,
                  output ready);
endinterface

interface dmgs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dmgs_pkg::CFG_IDX_W-1:0]  index;
  logic [dmgs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/dmgs_core.sv =====
module dmgs_core #(
  parameter int unsigned ROWS = dmgs_pkg::ROWS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  input  logic                           item_func_i,
  input  logic [dmgs_pkg::CODE_W-1:0]    item_code_i,
  input  logic [dmgs_pkg::REFRESH_W-1:0] refresh_period_i,
  input  logic [dmgs_pkg::ANIMATE_W-1:0] animate_period_i,
  output dmgs_pkg::push_t                push_o
);

  localparam int unsigned RW = $clog2(ROWS);
  localparam logic [RW:0]   ROWS_V   = (RW+1)'(ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  logic [dmgs_pkg::GLYPH_W-1:0]   glyph_q, glyph_d;
  logic [RW-1:0]                  scan_q, scan_d;
  logic [RW-1:0]                  offset_q, offset_d;
  logic [dmgs_pkg::REFRESH_W-1:0] refresh_cnt_q, refresh_cnt_d;
  logic [dmgs_pkg::ANIMATE_W-1:0] animate_cnt_q, animate_cnt_d;

  logic                           tick;
  logic                           refresh_fire;
  logic                           animate_fire;
  logic [RW:0]                    row_sum;
  logic [RW:0]                    font_row_full;
  logic [RW+dmgs_pkg::OUT_ROW_W:0] scan_ext;
  logic [RW+dmgs_pkg::OUT_ROW_W:0] font_ext;
  logic [dmgs_pkg::REFRESH_W-1:0] refresh_per;
  logic [dmgs_pkg::ANIMATE_W-1:0] animate_per;
  logic [dmgs_pkg::REFRESH_W:0]   refresh_inc;
  logic [dmgs_pkg::ANIMATE_W:0]   animate_inc;

  assign tick         = item_valid_i && (item_func_i == dmgs_pkg::FUNC_TICK);
  assign refresh_fire = tick && (refresh_cnt_q == '0);
  assign animate_fire = tick && (animate_cnt_q == '0);

  // Font row is the scan row rotated by the offset; the sum stays below twice ROWS.
  assign row_sum       = {1'b0, scan_q} + {1'b0, offset_q};
  assign font_row_full = (row_sum >= ROWS_V) ? (row_sum - ROWS_V) : row_sum;
  assign scan_ext      = {{dmgs_pkg::OUT_ROW_W{1'b0}}, 1'b0, scan_q};
  assign font_ext      = {{dmgs_pkg::OUT_ROW_W{1'b0}}, font_row_full};

  assign push_o.valid           = refresh_fire;
  assign push_o.item.scan_row   = scan_ext[dmgs_pkg::OUT_ROW_W-1:0];
  assign push_o.item.font_glyph = glyph_q;
  assign push_o.item.font_row   = font_ext[dmgs_pkg::OUT_ROW_W-1:0];

  // A period of zero behaves as a period of one.
  assign refresh_per = (refresh_period_i == '0) ? dmgs_pkg::REFRESH_W'(1) : refresh_period_i;
  assign animate_per = (animate_period_i == '0) ? dmgs_pkg::ANIMATE_W'(1) : animate_period_i;
  assign refresh_inc = {1'b0, refresh_cnt_q} + (dmgs_pkg::REFRESH_W+1)'(1);
  assign animate_inc = {1'b0, animate_cnt_q} + (dmgs_pkg::ANIMATE_W+1)'(1);

  always_comb begin
    glyph_d       = glyph_q;
    scan_d        = scan_q;
    offset_d      = offset_q;
    refresh_cnt_d = refresh_cnt_q;
    animate_cnt_d = animate_cnt_q;
    if (item_valid_i && (item_func_i == dmgs_pkg::FUNC_SET)) begin
      glyph_d = dmgs_pkg::map_code(item_code_i);
    end
    if (refresh_fire) begin
      scan_d = (scan_q == LAST_ROW) ? '0 : scan_q + RW'(1);
    end
    if (animate_fire) begin
      if (glyph_q == dmgs_pkg::GLYPH_UP) begin
        offset_d = (offset_q == LAST_ROW) ? '0 : offset_q + RW'(1);
      end else if (glyph_q == dmgs_pkg::GLYPH_DOWN) begin
        offset_d = (offset_q == '0) ? LAST_ROW : offset_q - RW'(1);
      end else begin
        offset_d = '0;
      end
    end
    if (tick) begin
      refresh_cnt_d = (refresh_inc >= {1'b0, refresh_per}) ? '0
                                                           : refresh_inc[dmgs_pkg::REFRESH_W-1:0];
      animate_cnt_d = (animate_inc >= {1'b0, animate_per}) ? '0
                                                           : animate_inc[dmgs_pkg::ANIMATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_q       <= dmgs_pkg::GLYPH_BLANK;
      scan_q        <= '0;
      offset_q      <= '0;
      refresh_cnt_q <= '0;
      animate_cnt_q <= '0;
    end else begin
      glyph_q       <= glyph_d;
      scan_q        <= scan_d;
      offset_q      <= offset_d;
      refresh_cnt_q <= refresh_cnt_d;
      animate_cnt_q <= animate_cnt_d;
    end
  end

endmodule

// ===== rtl/core/dmgs_out_fifo.sv =====
module dmgs_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dmgs_pkg::push_t       push_i,
  input  logic                  pop_i,
  output dmgs_pkg::result_t     head_o,
  output dmgs_pkg::fifo_stat_t  stat_o
);

  localparam logic [dmgs_pkg::OUT_PTR_W-1:0] LAST_PTR =
    dmgs_pkg::OUT_PTR_W'(dmgs_pkg::OUT_DEPTH - 1);

  dmgs_pkg::result_t                  mem_q [dmgs_pkg::OUT_DEPTH];
  logic [dmgs_pkg::OUT_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [dmgs_pkg::OUT_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [dmgs_pkg::OUT_CNT_W-1:0]     count_q, count_d;
  logic                               do_pop;

  assign do_pop       = pop_i && (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + dmgs_pkg::OUT_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + dmgs_pkg::OUT_PTR_W'(1);
    end
    case ({push_i.valid, do_pop})
      2'b10:   count_d = count_q + dmgs_pkg::OUT_CNT_W'(1);
      2'b01:   count_d = count_q - dmgs_pkg::OUT_CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/core/dot_matrix_glyph_scanner.sv =====
// Path: an accepted item is held in the input register; a tick that fires a row
// refresh then pushes its result through the state update into the three-entry
// output queue, whose head drives out_o. Throughput: one item per cycle while the
// credit check lets items in. Reset: rst_ni is asynchronous and active low; it
// restores the periods to 10 and 300, the glyph to blank, the scan row, offset and
// both tick counters to zero.
module dot_matrix_glyph_scanner #(
  parameter int unsigned ROWS = dmgs_pkg::ROWS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dmgs_in_if.sink     in_i,
  dmgs_out_if.source  out_o,
  dmgs_cfg_if.sink    cfg_i
);

  // Configuration registers take writes in any cycle, unchecked; the user must issue
  // them only while the block is idle, so no item sees a half-updated period.
  logic [dmgs_pkg::REFRESH_W-1:0] refresh_period_q;
  logic [dmgs_pkg::ANIMATE_W-1:0] animate_period_q;
  logic                           cfg_write;

  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_period_q <= dmgs_pkg::REFRESH_RESET;
      animate_period_q <= dmgs_pkg::ANIMATE_RESET;
    end else if (cfg_write) begin
      case (cfg_i.index)
        dmgs_pkg::REG_REFRESH_PERIOD: refresh_period_q <= cfg_i.data[dmgs_pkg::REFRESH_W-1:0];
        dmgs_pkg::REG_ANIMATE_PERIOD: animate_period_q <= cfg_i.data[dmgs_pkg::ANIMATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register. Every accepted item is held here before it updates
  // the scanner state.
  logic                        stage_valid_q;
  logic                        stage_func_q;
  logic [dmgs_pkg::CODE_W-1:0] stage_code_q;
  logic                        in_xfer;

  // Credit check: an item is taken only if the output queue has room for the item
  // already in the input register and for this one, whatever the sink does.
  dmgs_pkg::fifo_stat_t          fifo_stat;
  logic [dmgs_pkg::OUT_CNT_W:0]  in_flight;

  assign in_flight  = {1'b0, fifo_stat.count} + (dmgs_pkg::OUT_CNT_W+1)'(stage_valid_q);
  assign in_i.ready = (in_flight < (dmgs_pkg::OUT_CNT_W+1)'(dmgs_pkg::OUT_DEPTH));
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stage_func_q <= in_i.func;
      stage_code_q <= in_i.code;
    end
  end

  // Scanner state: glyph, scan row, row offset and the two tick counters. A refresh
  // tick pushes one result into the output queue in the same cycle.
  dmgs_pkg::push_t push;

  dmgs_core #(
    .ROWS(ROWS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (stage_valid_q),
    .item_func_i     (stage_func_q),
    .item_code_i     (stage_code_q),
    .refresh_period_i(refresh_period_q),
    .animate_period_i(animate_period_q),
    .push_o          (push)
  );

  // Output queue, which decouples the scanner from stalls on the result side.
  dmgs_pkg::result_t head;

  dmgs_out_fifo u_out_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (out_o.ready),
    .head_o(head),
    .stat_o(fifo_stat)
  );

  assign out_o.valid      = !fifo_stat.empty;
  assign out_o.scan_row   = head.scan_row;
  assign out_o.font_glyph = head.font_glyph;
  assign out_o.font_row   = head.font_row;

  // The credit check must keep the queue from ever being pushed while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> (fifo_stat.count != dmgs_pkg::OUT_CNT_W'(dmgs_pkg::OUT_DEPTH)))
    else $error("output queue pushed while full");

  // Results come only from an item held in the input register, and never from a set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> (stage_valid_q && (stage_func_q == dmgs_pkg::FUNC_TICK)))
    else $error("result pushed without a tick in the input register");

  // An accepted item always lands in the input register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> stage_valid_q)
    else $error("accepted item lost before the state update");

  // With the queue full, no new item may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_stat.count == dmgs_pkg::OUT_CNT_W'(dmgs_pkg::OUT_DEPTH)) |-> !in_i.ready)
    else $error("input accepted while output queue full");

endmodule

// ===== verif/dot_matrix_glyph_scanner_test.sv =====
`timescale 1ns / 1ps

module dot_matrix_glyph_scanner_test;
  import dmgs_pkg::*;

  localparam int unsigned ROWS = ROWS_DEFAULT;
  // Cycles that a set command may still spend inside the block after the last
  // row refresh has come out.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Length of the deliberate receiver hold-off that fills the block up.
  localparam int unsigned LONG_STALL = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One command as it travels on the input channel.
  typedef struct {
    func_e             func;
    logic [CODE_W-1:0] code;
  } command_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dmgs_in_if  cmd_if ();
  dmgs_out_if row_if ();
  dmgs_cfg_if reg_if ();

  dot_matrix_glyph_scanner dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (row_if),
    .cfg_i  (reg_if)
  );

  always #5 clk_i = ~clk_i;

  // Commands waiting to be offered, and the row refreshes that the accepted
  // ticks are owed, oldest first.
  command_t pending_commands[$];
  result_t  refreshes_due[$];

  // Random idling, in percent of cycles, set per phase by the sequencer.
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  // The sequencer bumps stall_requests; the hold-off process notices the change
  // and then keeps the receiver off while its countdown from LONG_STALL runs.
  int unsigned stall_requests = 0;
  int unsigned stall_served;
  int unsigned stall_left;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Scanner state as the predictor sees it, at the widths of the block.
  logic [REFRESH_W-1:0] refresh_len;
  logic [ANIMATE_W-1:0] animate_len;
  logic [GLYPH_W-1:0]   shown_glyph;
  logic [OUT_ROW_W-1:0] active_row;
  logic [OUT_ROW_W-1:0] row_shift;
  logic [REFRESH_W-1:0] refresh_ticks;
  logic [ANIMATE_W-1:0] animate_ticks;

  // Gear letters other than up and down.
  logic [CODE_W-1:0] gear_letters[5] = '{CODE_AUTO, CODE_SPORT, CODE_QUIT, CODE_WAIT,
                                         CODE_LOCK};

  // Glyph that a command byte selects; anything unknown shows the blank glyph.
  function automatic logic [GLYPH_W-1:0] glyph_for_code(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] offset;
    offset = code - CODE_DIGIT_LO;
    if (code >= CODE_DIGIT_LO && code <= CODE_DIGIT_HI) begin
      return offset[GLYPH_W-1:0];
    end
    case (code)
      CODE_UP:    return GLYPH_UP;
      CODE_DOWN:  return GLYPH_DOWN;
      CODE_AUTO:  return GLYPH_AUTO;
      CODE_SPORT: return GLYPH_SPORT;
      CODE_QUIT:  return GLYPH_QUIT;
      CODE_WAIT:  return GLYPH_WAIT;
      CODE_LOCK:  return GLYPH_LOCK;
      default:    return GLYPH_BLANK;
    endcase
  endfunction

  // Next value of a tick counter. A period of zero behaves as one, and a count
  // that already sits at or beyond the last value of a lowered period wraps.
  function automatic int unsigned next_tick_count(input int unsigned count,
                                                  input int unsigned period);
    int unsigned span;
    span = (period == 0) ? 1 : period;
    return (count + 1 >= span) ? 0 : count + 1;
  endfunction

  task automatic reset_scanner_model();
    refresh_len   = REFRESH_RESET;
    animate_len   = ANIMATE_RESET;
    shown_glyph   = GLYPH_BLANK;
    active_row    = '0;
    row_shift     = '0;
    refresh_ticks = '0;
    animate_ticks = '0;
  endtask

  // Applies one accepted command to the predicted state and queues the row
  // refresh that it causes, if any.
  task automatic scan_command(input command_t cmd);
    result_t refresh;
    if (cmd.func == FUNC_SET) begin
      shown_glyph = glyph_for_code(cmd.code);
    end else begin
      if (refresh_ticks == 0) begin
        refresh.scan_row   = active_row;
        refresh.font_glyph = shown_glyph;
        refresh.font_row   = OUT_ROW_W'((int'(active_row) + int'(row_shift)) % ROWS);
        refreshes_due.push_back(refresh);
        active_row = OUT_ROW_W'((int'(active_row) + 1) % ROWS);
      end
      // The offset moves after the refresh, so a refresh on the same tick
      // still shows the old offset.
      if (animate_ticks == 0) begin
        if (shown_glyph == GLYPH_UP) begin
          row_shift = OUT_ROW_W'((int'(row_shift) + 1) % ROWS);
        end else if (shown_glyph == GLYPH_DOWN) begin
          row_shift = OUT_ROW_W'((int'(row_shift) + ROWS - 1) % ROWS);
        end else begin
          row_shift = '0;
        end
      end
      refresh_ticks = REFRESH_W'(next_tick_count(refresh_ticks, refresh_len));
      animate_ticks = ANIMATE_W'(next_tick_count(animate_ticks, animate_len));
    end
  endtask

  // Command driver. An offered command stays on the bus until its transfer;
  // after that the next one is offered unless a random gap is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.func  <= 1'b0;
      cmd_if.code  <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        scan_command(pending_commands.pop_front());
      end
      if (cmd_if.valid && !cmd_if.ready) begin
        cmd_if.valid <= 1'b1;
      end else if (pending_commands.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        cmd_if.valid <= 1'b1;
        cmd_if.func  <= pending_commands[0].func;
        cmd_if.code  <= pending_commands[0].code;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so that the sequencer only asks for it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_served <= 0;
      stall_left   <= 0;
    end else if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      stall_left   <= LONG_STALL;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Row refresh monitor. Each transfer is checked against the oldest refresh due.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_if.ready <= 1'b0;
    end else begin
      if (row_if.valid && row_if.ready) begin
        if (refreshes_due.size() == 0) begin
          $display("%0t: row refresh with none due: scan_row %0d font_glyph %0d font_row %0d",
                   $time, row_if.scan_row, row_if.font_glyph, row_if.font_row);
          mismatches++;
        end else begin
          if (row_if.scan_row !== refreshes_due[0].scan_row) begin
            $display("%0t: scan_row expected %0d, got %0d", $time,
                     refreshes_due[0].scan_row, row_if.scan_row);
            mismatches++;
          end
          if (row_if.font_glyph !== refreshes_due[0].font_glyph) begin
            $display("%0t: font_glyph expected %0d, got %0d", $time,
                     refreshes_due[0].font_glyph, row_if.font_glyph);
            mismatches++;
          end
          if (row_if.font_row !== refreshes_due[0].font_row) begin
            $display("%0t: font_row expected %0d, got %0d", $time,
                     refreshes_due[0].font_row, row_if.font_row);
            mismatches++;
          end
          void'(refreshes_due.pop_front());
        end
      end
      row_if.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hard stop in case the block hangs on either channel.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands unsent, %0d refreshes due",
               cycle_count, pending_commands.size(), refreshes_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Waits until every command has gone in and every refresh it owed has come
  // out, then lets a trailing set command settle inside the block.
  task automatic drain();
    while (pending_commands.size() != 0 || refreshes_due.size() != 0 || cmd_if.valid) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes one period register; the predictor takes the new value at the transfer.
  task automatic write_period(input cfg_reg_e index, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    reg_if.valid <= 1'b1;
    reg_if.index <= index;
    reg_if.data  <= data;
    do @(posedge clk_i); while (!reg_if.ready);
    reg_if.valid <= 1'b0;
    if (index == REG_REFRESH_PERIOD) begin
      refresh_len = data[REFRESH_W-1:0];
    end else begin
      animate_len = data[ANIMATE_W-1:0];
    end
  endtask

  task automatic queue_command(input func_e func, input logic [CODE_W-1:0] code);
    command_t cmd;
    cmd.func = func;
    cmd.code = code;
    pending_commands.push_back(cmd);
  endtask

  // Mostly ticks, with a set now and then. Up and down are favored so that the
  // offset gets to climb and fall through its whole range between sets.
  task automatic queue_random_commands(input int unsigned count, input int unsigned set_pct);
    logic [CODE_W-1:0] code;
    repeat (count) begin
      code = CODE_W'($urandom);
      if ($urandom_range(99) < set_pct) begin
        case ($urandom_range(4))
          0: code = CODE_DIGIT_LO + CODE_W'($urandom_range(12));
          1: code = CODE_UP;
          2: code = CODE_DOWN;
          3: code = gear_letters[$urandom_range(4)];
          default: ;
        endcase
        queue_command(FUNC_SET, code);
      end else begin
        queue_command(FUNC_TICK, code);
      end
    end
  endtask

  // One phase: the block is drained, both periods are written while it is idle,
  // and then a batch of commands runs under the given idling.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] refresh_data,
                           input logic [CFG_DATA_W-1:0] animate_data,
                           input int unsigned gap_pct, input int unsigned stall_pct,
                           input int unsigned count, input int unsigned set_pct);
    drain();
    write_period(REG_REFRESH_PERIOD, refresh_data);
    write_period(REG_ANIMATE_PERIOD, animate_data);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    queue_random_commands(count, set_pct);
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.func  = 1'b0;
    cmd_if.code  = '0;
    row_if.ready = 1'b0;
    reg_if.valid = 1'b0;
    reg_if.index = REG_REFRESH_PERIOD;
    reg_if.data  = '0;
    rst_ni       = 1'b0;
    reset_scanner_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A few ticks under the reset periods: the very first tick must refresh
    // row zero with the blank glyph.
    repeat (3) queue_command(FUNC_TICK, 8'h00);
    drain();

    // Directed part with both periods at one, so that every tick refreshes a
    // row and updates the offset.
    write_period(REG_REFRESH_PERIOD, 16'd1);
    write_period(REG_ANIMATE_PERIOD, 16'd1);
    queue_command(FUNC_SET,  CODE_DIGIT_LO);
    queue_command(FUNC_TICK, 8'hFF);
    queue_command(FUNC_SET,  CODE_DIGIT_HI);
    queue_command(FUNC_TICK, 8'h00);
    queue_command(FUNC_SET,  CODE_UP);
    repeat (3) queue_command(FUNC_TICK, 8'h00);
    queue_command(FUNC_SET,  CODE_DOWN);
    repeat (4) queue_command(FUNC_TICK, 8'hA5);
    foreach (gear_letters[i]) queue_command(FUNC_SET, gear_letters[i]);
    queue_command(FUNC_TICK, 8'h5A);
    // Codes just outside the digit range and at the ends of the byte are blank.
    queue_command(FUNC_SET,  CODE_DIGIT_LO - 8'd1);
    queue_command(FUNC_TICK, 8'h00);
    queue_command(FUNC_SET,  CODE_DIGIT_HI + 8'd1);
    queue_command(FUNC_SET,  8'h00);
    queue_command(FUNC_SET,  8'hFF);
    queue_command(FUNC_TICK, 8'hFF);

    // Full speed with every tick refreshing a row. The long hold-off on the
    // receiver fills the output queue, so the block must stall its input.
    run_phase(16'd1, 16'd3, 0, 0, 80, 15);
    stall_requests++;

    // Sender idling, split by a pause until every refresh has come out.
    run_phase(16'd3, 16'd7, 58, 0, 60, 15);
    run_phase(16'd2, 16'd1, 58, 0, 60, 20);

    // Receiver stalling.
    run_phase(16'd1, 16'd2, 0, 58, 100, 15);

    // Zero periods behave as one; the bits above the refresh field are dropped.
    run_phase(16'hFC00, 16'd0, 21, 21, 100, 15);

    // Longest periods: mostly ticks, enough for the refresh counter to wrap.
    run_phase(16'h03FF, 16'hFFFF, 0, 0, 1060, 1);

    // Shorter periods again while both counters sit far beyond them.
    run_phase(16'd2, 16'd5, 21, 21, 80, 15);

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
